FILE: rtl/wsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wall slice projection package
// Shared constants, register codes and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package wsp_pkg;

    // Register codes, taken from paddr[3:2].
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_SCREEN_HEIGHT = 2'd0;
    localparam reg_idx_t REG_SCREEN_WIDTH  = 2'd1;
    localparam reg_idx_t REG_RAY_COUNT     = 2'd2;

    localparam int unsigned CFG_W  = 12;
    localparam int unsigned DIST_W = 24;
    localparam int unsigned COS_W  = 16;
    localparam int unsigned TEX_W  = 6;
    localparam int unsigned COL_W  = 11;
    localparam int unsigned TOP_W  = 11;
    localparam int unsigned ROW_W  = 16;

    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd512;
    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 12'd1024;
    localparam logic [CFG_W-1:0] RAY_COUNT_RST     = 12'd256;

    // Cosine over one quarter turn in 32 segments, Q1.15.
    function automatic logic [COS_W-1:0] cos_rom(input logic [5:0] idx);
        logic [COS_W-1:0] val;
        case (idx)
            6'd0:  val = 16'd32768;
            6'd1:  val = 16'd32729;
            6'd2:  val = 16'd32610;
            6'd3:  val = 16'd32413;
            6'd4:  val = 16'd32138;
            6'd5:  val = 16'd31786;
            6'd6:  val = 16'd31357;
            6'd7:  val = 16'd30853;
            6'd8:  val = 16'd30274;
            6'd9:  val = 16'd29622;
            6'd10: val = 16'd28899;
            6'd11: val = 16'd28106;
            6'd12: val = 16'd27246;
            6'd13: val = 16'd26320;
            6'd14: val = 16'd25330;
            6'd15: val = 16'd24279;
            6'd16: val = 16'd23170;
            6'd17: val = 16'd22006;
            6'd18: val = 16'd20788;
            6'd19: val = 16'd19520;
            6'd20: val = 16'd18205;
            6'd21: val = 16'd16846;
            6'd22: val = 16'd15447;
            6'd23: val = 16'd14010;
            6'd24: val = 16'd12540;
            6'd25: val = 16'd11039;
            6'd26: val = 16'd9512;
            6'd27: val = 16'd7962;
            6'd28: val = 16'd6393;
            6'd29: val = 16'd4808;
            6'd30: val = 16'd3212;
            6'd31: val = 16'd1608;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/wall_slice_projection_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wall slice projection unit
// Turns one ray hit into the wall column to draw: fisheye correction, wall
// height, texture step and start row, screen column and texture column.
// ----------------------------------------------------------------------------
// An item passes through the front end, the height and strip dividers, the
// back end with its texture step divider, and the output register.
// Throughput is one item per cycle while the skid register is empty: all
// three dividers are fully pipelined with one quotient bit per stage, and a
// skid register keeps input flowing while a result waits. Reset clears all
// valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module wall_slice_projection_unit #(
    parameter int unsigned TEXTURE_SIZE     = 64,
    parameter int unsigned PROJECTION_SCALE = 128,
    parameter int unsigned ANGLE_BITS       = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_player_angle,
    input  wire logic [15:0] s_ray_angle,
    input  wire logic signed [15:0] s_sway_angle,
    input  wire logic [23:0] s_hit_distance,
    input  wire logic [15:0] s_hit_x,
    input  wire logic [15:0] s_hit_y,
    input  wire logic        s_hit_on_horizontal,
    input  wire logic [10:0] s_ray_index,
    // Result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [11:0]      m_wall_height,
    output logic [10:0]      m_wall_top,
    output logic [10:0]      m_column_x,
    output logic [5:0]       m_tex_column,
    output logic [15:0]      m_tex_row_start,
    output logic [15:0]      m_tex_row_step,
    output logic [23:0]      m_corrected_distance
);
    import wsp_pkg::*;

    // Width of the largest height numerator, PROJECTION_SCALE * 4095 * 256.
    localparam int unsigned NUM_W  = $clog2(PROJECTION_SCALE * 4095 * 256 + 1);
    localparam int unsigned OUT_W  = CFG_W + TOP_W + COL_W + TEX_W + 2*ROW_W + DIST_W;
    localparam int unsigned SIDEA_W = DIST_W + TEX_W + CFG_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the access phase; the
    // port never waits, so pready is tied high.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] screen_height_reg, screen_width_reg, ray_count_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_height_reg <= SCREEN_HEIGHT_RST;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            ray_count_reg     <= RAY_COUNT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[CFG_W-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[CFG_W-1:0];
                REG_RAY_COUNT:     ray_count_reg     <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SCREEN_HEIGHT: prdata = 32'(screen_height_reg);
            REG_SCREEN_WIDTH:  prdata = 32'(screen_width_reg);
            REG_RAY_COUNT:     prdata = 32'(ray_count_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline advance. Every stage moves together while the skid register
    // is empty; a held result only stops the pipe once the skid also fills.
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic pipe_en;

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    // Front end: angle, cosine and distance correction in four stages.
    logic              fr_valid;
    logic [DIST_W-1:0] fr_cd;
    logic [NUM_W-1:0]  fr_num;
    logic [TEX_W-1:0]  fr_tex;
    logic [CFG_W-1:0]  fr_h, fr_w, fr_rc;
    logic [10:0]       fr_ridx;

    wsp_front #(
        .TEXTURE_SIZE     (TEXTURE_SIZE),
        .PROJECTION_SCALE (PROJECTION_SCALE),
        .ANGLE_BITS       (ANGLE_BITS),
        .NUM_W            (NUM_W)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (pipe_en),
        .in_valid          (s_valid),
        .player_angle      (s_player_angle),
        .ray_angle         (s_ray_angle),
        .sway_angle        (s_sway_angle),
        .hit_distance      (s_hit_distance),
        .hit_x             (s_hit_x),
        .hit_y             (s_hit_y),
        .hit_on_horizontal (s_hit_on_horizontal),
        .ray_index         (s_ray_index),
        .screen_height     (screen_height_reg),
        .screen_width      (screen_width_reg),
        .ray_count         (ray_count_reg),
        .out_valid         (fr_valid),
        .out_cd            (fr_cd),
        .out_num           (fr_num),
        .out_tex           (fr_tex),
        .out_h             (fr_h),
        .out_w             (fr_w),
        .out_rc            (fr_rc),
        .out_ridx          (fr_ridx)
    );

    // Height division. A corrected distance of zero divides as one unit.
    logic [DIST_W-1:0]  div_den;
    logic               dva_valid;
    logic [NUM_W-1:0]   raw_quo;
    logic [SIDEA_W-1:0] dva_side;
    logic [DIST_W-1:0]  cd_a;
    logic [TEX_W-1:0]   tex_a;
    logic [CFG_W-1:0]   h_a;
    logic               rc_zero_a;

    assign div_den = (fr_cd == '0) ? DIST_W'(1) : fr_cd;

    wsp_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (DIST_W),
        .SIDE_W (SIDEA_W)
    ) u_height_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (fr_valid),
        .in_num    (fr_num),
        .in_den    (div_den),
        .in_side   ({fr_cd, fr_tex, fr_h, (fr_rc == '0)}),
        .out_valid (dva_valid),
        .out_quo   (raw_quo),
        .out_side  (dva_side)
    );

    assign {cd_a, tex_a, h_a, rc_zero_a} = dva_side;

    // Strip width, screen_width / ray_count, runs beside the height divider
    // with the same depth so both answers meet at the back end.
    logic             dvb_valid;
    logic [NUM_W-1:0] span_quo;
    logic [10:0]      ridx_b;

    wsp_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (DIST_W),
        .SIDE_W (11)
    ) u_span_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (fr_valid),
        .in_num    (NUM_W'(fr_w)),
        .in_den    (DIST_W'(fr_rc)),
        .in_side   (fr_ridx),
        .out_valid (dvb_valid),
        .out_quo   (span_quo),
        .out_side  (ridx_b)
    );

    // Back end: texture step division, clipping and start row.
    logic              bk_valid;
    logic [CFG_W-1:0]  bk_height;
    logic [TOP_W-1:0]  bk_top;
    logic [COL_W-1:0]  bk_col;
    logic [TEX_W-1:0]  bk_tex;
    logic [ROW_W-1:0]  bk_start, bk_step;
    logic [DIST_W-1:0] bk_cd;

    wsp_back #(
        .TEXTURE_SIZE (TEXTURE_SIZE),
        .NUM_W        (NUM_W)
    ) u_back (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .en                     (pipe_en),
        .in_valid               (dva_valid && dvb_valid),
        .raw_quo                (raw_quo),
        .span_quo               (span_quo),
        .ridx                   (ridx_b),
        .rc_zero                (rc_zero_a),
        .cd                     (cd_a),
        .tex                    (tex_a),
        .h                      (h_a),
        .out_valid              (bk_valid),
        .out_wall_height        (bk_height),
        .out_wall_top           (bk_top),
        .out_column_x           (bk_col),
        .out_tex_column         (bk_tex),
        .out_tex_row_start      (bk_start),
        .out_tex_row_step       (bk_step),
        .out_corrected_distance (bk_cd)
    );

    // ------------------------------------------------------------------
    // Output register with a skid stage behind it. When the output holds
    // an item that is not taken, the next finished item parks in the skid
    // register and the pipe stops until it drains.
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] pipe_data;
    logic [OUT_W-1:0] out_data_reg, skid_data_reg;
    logic             out_valid_reg;
    logic             out_free;

    assign pipe_data = {bk_height, bk_top, bk_col, bk_tex, bk_start, bk_step, bk_cd};
    assign out_free  = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= bk_valid;
            end
        end else if (bk_valid && pipe_en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : pipe_data;
        end else if (pipe_en) begin
            skid_data_reg <= pipe_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign {m_wall_height, m_wall_top, m_column_x, m_tex_column,
            m_tex_row_start, m_tex_row_step, m_corrected_distance} = out_data_reg;

endmodule
`default_nettype wire

FILE: rtl/wsp_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, NUM_W stages, with a side word carried along.
// ----------------------------------------------------------------------------
module wsp_div_pipe #(
    parameter int unsigned NUM_W  = 8,
    parameter int unsigned DEN_W  = 8,
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       out_quo,
    output logic [SIDE_W-1:0]      out_side
);
    logic              vld_reg  [NUM_W];
    logic [NUM_W-1:0]  nq_reg   [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W-1];
    logic [DEN_W-1:0]  den_reg  [NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              src_vld;
        logic [DEN_W-1:0]  src_rem;
        logic [DEN_W-1:0]  src_den;
        logic [NUM_W-1:0]  src_nq;
        logic [SIDE_W-1:0] src_side;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              qbit;

        if (k == 0) begin : g_first
            assign src_vld  = in_valid;
            assign src_rem  = '0;
            assign src_den  = in_den;
            assign src_nq   = in_num;
            assign src_side = in_side;
        end else begin : g_rest
            assign src_vld  = vld_reg[k-1];
            assign src_rem  = rem_reg[k-1];
            assign src_den  = den_reg[k-1];
            assign src_nq   = nq_reg[k-1];
            assign src_side = side_reg[k-1];
        end

        // The numerator shifts out at the top while quotient bits shift in below.
        always_comb begin
            trial = {src_rem, src_nq[NUM_W-1]};
            diff  = trial - {1'b0, src_den};
            qbit  = (trial >= {1'b0, src_den});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[k]   <= {src_nq[NUM_W-2:0], qbit};
                side_reg[k] <= src_side;
            end
        end

        if (k < NUM_W - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    den_reg[k] <= src_den;
                end
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quo   = nq_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule
`default_nettype wire

FILE: rtl/wsp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wall slice projection front end
// Angle wrap, cosine lookup and interpolation, fisheye distance correction.
// ----------------------------------------------------------------------------
module wsp_front #(
    parameter int unsigned TEXTURE_SIZE     = 64,
    parameter int unsigned PROJECTION_SCALE = 128,
    parameter int unsigned ANGLE_BITS       = 16,
    parameter int unsigned NUM_W            = 27
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [15:0]                  player_angle,
    input  wire logic [15:0]                  ray_angle,
    input  wire logic signed [15:0]           sway_angle,
    input  wire logic [wsp_pkg::DIST_W-1:0]   hit_distance,
    input  wire logic [15:0]                  hit_x,
    input  wire logic [15:0]                  hit_y,
    input  wire logic                         hit_on_horizontal,
    input  wire logic [10:0]                  ray_index,
    input  wire logic [wsp_pkg::CFG_W-1:0]    screen_height,
    input  wire logic [wsp_pkg::CFG_W-1:0]    screen_width,
    input  wire logic [wsp_pkg::CFG_W-1:0]    ray_count,
    output logic                              out_valid,
    output logic [wsp_pkg::DIST_W-1:0]        out_cd,
    output logic [NUM_W-1:0]                  out_num,
    output logic [wsp_pkg::TEX_W-1:0]         out_tex,
    output logic [wsp_pkg::CFG_W-1:0]         out_h,
    output logic [wsp_pkg::CFG_W-1:0]         out_w,
    output logic [wsp_pkg::CFG_W-1:0]         out_rc,
    output logic [10:0]                       out_ridx
);
    import wsp_pkg::*;

    localparam int unsigned AB       = ANGLE_BITS;
    localparam int unsigned SEG      = ANGLE_BITS - 7;
    localparam int unsigned TEX_BITS = $clog2(TEXTURE_SIZE);
    localparam int unsigned NUM_K    = PROJECTION_SCALE * 256;
    localparam logic [AB-1:0] QUARTER_A = {2'b01, {(AB-2){1'b0}}};
    localparam logic [AB-1:0] HALF_A    = {2'b10, {(AB-2){1'b0}}};
    localparam logic [AB-1:0] THREE_Q_A = {2'b11, {(AB-2){1'b0}}};
    localparam logic [AB-2:0] QUARTER_R = {1'b1, {(AB-2){1'b0}}};

    // Stage 1: wrapped angle difference and texture column.
    logic [31:0]         pa_w, ra_w, sw_w, ca_w;
    logic [AB-1:0]       ra_m;
    logic [TEX_BITS-1:0] tex_raw, tex_mir;
    logic                mirror;
    logic [31:0]         tex_w;

    always_comb begin
        pa_w = {16'd0, player_angle};
        ra_w = {16'd0, ray_angle};
        sw_w = {{16{sway_angle[15]}}, sway_angle};
        ca_w = pa_w - ra_w - sw_w;
        ra_m = ra_w[AB-1:0];
        if (hit_on_horizontal) begin
            tex_raw = hit_x[TEX_BITS:1];
            mirror  = (ra_m < HALF_A);
        end else begin
            tex_raw = hit_y[TEX_BITS:1];
            mirror  = (ra_m > QUARTER_A) && (ra_m < THREE_Q_A);
        end
        tex_mir = mirror ? ~tex_raw : tex_raw;
        tex_w   = 32'(tex_mir);
    end

    logic                v1_reg;
    logic [AB-1:0]       ca1_reg;
    logic [DIST_W-1:0]   d1_reg;
    logic [TEX_W-1:0]    t1_reg;
    logic [CFG_W-1:0]    h1_reg, w1_reg, rc1_reg;
    logic [10:0]         r1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ca1_reg <= ca_w[AB-1:0];
            d1_reg  <= hit_distance;
            t1_reg  <= tex_w[TEX_W-1:0];
            h1_reg  <= screen_height;
            w1_reg  <= screen_width;
            rc1_reg <= ray_count;
            r1_reg  <= ray_index;
        end
    end

    // Stage 2: quadrant fold and table lookup. The back half turn gives zero.
    logic [1:0]     quad;
    logic [AB-3:0]  rem_ang;
    logic [AB-2:0]  folded;
    logic [5:0]     idx;
    logic [SEG-1:0] frac;
    logic [COS_W-1:0] a_val, d_val;

    always_comb begin
        quad    = ca1_reg[AB-1:AB-2];
        rem_ang = ca1_reg[AB-3:0];
        folded  = (quad == 2'd0) ? {1'b0, rem_ang} : (QUARTER_R - {1'b0, rem_ang});
        idx     = folded[AB-2:SEG];
        frac    = folded[SEG-1:0];
        if ((quad[1] ^ quad[0]) || idx[5]) begin
            a_val = '0;
            d_val = '0;
        end else begin
            a_val = cos_rom(idx);
            d_val = a_val - cos_rom(idx + 6'd1);
        end
    end

    logic                v2_reg;
    logic [COS_W-1:0]    a2_reg, dd2_reg;
    logic [SEG-1:0]      f2_reg;
    logic [DIST_W-1:0]   d2_reg;
    logic [TEX_W-1:0]    t2_reg;
    logic [CFG_W-1:0]    h2_reg, w2_reg, rc2_reg;
    logic [10:0]         r2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a2_reg  <= a_val;
            dd2_reg <= d_val;
            f2_reg  <= frac;
            d2_reg  <= d1_reg;
            t2_reg  <= t1_reg;
            h2_reg  <= h1_reg;
            w2_reg  <= w1_reg;
            rc2_reg <= rc1_reg;
            r2_reg  <= r1_reg;
        end
    end

    // Stage 3: linear interpolation between table points.
    logic [COS_W+SEG-1:0] ip_prod, ip_shift;
    logic [COS_W-1:0]     cos_next;

    always_comb begin
        ip_prod  = (COS_W+SEG)'(dd2_reg) * (COS_W+SEG)'(f2_reg);
        ip_shift = ip_prod >> SEG;
        cos_next = a2_reg - ip_shift[COS_W-1:0];
    end

    logic                v3_reg;
    logic [COS_W-1:0]    cos3_reg;
    logic [DIST_W-1:0]   d3_reg;
    logic [TEX_W-1:0]    t3_reg;
    logic [CFG_W-1:0]    h3_reg, w3_reg, rc3_reg;
    logic [10:0]         r3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos3_reg <= cos_next;
            d3_reg   <= d2_reg;
            t3_reg   <= t2_reg;
            h3_reg   <= h2_reg;
            w3_reg   <= w2_reg;
            rc3_reg  <= rc2_reg;
            r3_reg   <= r2_reg;
        end
    end

    // Stage 4: corrected distance and the height numerator.
    logic [39:0] cd_prod;
    logic [31:0] num_full;

    always_comb begin
        cd_prod  = 40'(d3_reg) * 40'(cos3_reg);
        num_full = 32'(h3_reg) * 32'(NUM_K);
    end

    logic                v4_reg;
    logic [DIST_W-1:0]   cd4_reg;
    logic [NUM_W-1:0]    num4_reg;
    logic [TEX_W-1:0]    t4_reg;
    logic [CFG_W-1:0]    h4_reg, w4_reg, rc4_reg;
    logic [10:0]         r4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cd4_reg  <= cd_prod[38:15];
            num4_reg <= num_full[NUM_W-1:0];
            t4_reg   <= t3_reg;
            h4_reg   <= h3_reg;
            w4_reg   <= w3_reg;
            rc4_reg  <= rc3_reg;
            r4_reg   <= r3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_cd    = cd4_reg;
    assign out_num   = num4_reg;
    assign out_tex   = t4_reg;
    assign out_h     = h4_reg;
    assign out_w     = w4_reg;
    assign out_rc    = rc4_reg;
    assign out_ridx  = r4_reg;

endmodule
`default_nettype wire

FILE: rtl/wsp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wall slice projection back end
// Height clamp, texture step division, clipping, start row and screen column.
// ----------------------------------------------------------------------------
module wsp_back #(
    parameter int unsigned TEXTURE_SIZE = 64,
    parameter int unsigned NUM_W        = 27
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [NUM_W-1:0]           raw_quo,
    input  wire logic [NUM_W-1:0]           span_quo,
    input  wire logic [10:0]                ridx,
    input  wire logic                       rc_zero,
    input  wire logic [wsp_pkg::DIST_W-1:0] cd,
    input  wire logic [wsp_pkg::TEX_W-1:0]  tex,
    input  wire logic [wsp_pkg::CFG_W-1:0]  h,
    output logic                            out_valid,
    output logic [wsp_pkg::CFG_W-1:0]       out_wall_height,
    output logic [wsp_pkg::TOP_W-1:0]       out_wall_top,
    output logic [wsp_pkg::COL_W-1:0]       out_column_x,
    output logic [wsp_pkg::TEX_W-1:0]       out_tex_column,
    output logic [wsp_pkg::ROW_W-1:0]       out_tex_row_start,
    output logic [wsp_pkg::ROW_W-1:0]       out_tex_row_step,
    output logic [wsp_pkg::DIST_W-1:0]      out_corrected_distance
);
    import wsp_pkg::*;

    localparam int unsigned STEP_NUM = TEXTURE_SIZE * 1024;
    localparam int unsigned STEP_W   = $clog2(STEP_NUM + 1);
    localparam int unsigned SIDE_W   = NUM_W + COL_W + DIST_W + TEX_W + CFG_W;

    // Stage 1: height floor of one and screen column.
    logic [21:0] col_prod;
    always_comb begin
        col_prod = 22'(ridx) * 22'(span_quo[10:0]);
    end

    logic              v1_reg;
    logic [NUM_W-1:0]  raw1_reg;
    logic [COL_W-1:0]  col1_reg;
    logic [DIST_W-1:0] cd1_reg;
    logic [TEX_W-1:0]  t1_reg;
    logic [CFG_W-1:0]  h1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            raw1_reg <= (raw_quo == '0) ? NUM_W'(1) : raw_quo;
            col1_reg <= rc_zero ? '0 : col_prod[COL_W-1:0];
            cd1_reg  <= cd;
            t1_reg   <= tex;
            h1_reg   <= h;
        end
    end

    // Texture step divider.
    logic              dv_valid;
    logic [STEP_W-1:0] step_quo;
    logic [SIDE_W-1:0] dv_side;
    logic [NUM_W-1:0]  raw_d;
    logic [COL_W-1:0]  col_d;
    logic [DIST_W-1:0] cd_d;
    logic [TEX_W-1:0]  t_d;
    logic [CFG_W-1:0]  h_d;

    wsp_div_pipe #(
        .NUM_W  (STEP_W),
        .DEN_W  (NUM_W),
        .SIDE_W (SIDE_W)
    ) u_step_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v1_reg),
        .in_num    (STEP_W'(STEP_NUM)),
        .in_den    (raw1_reg),
        .in_side   ({raw1_reg, col1_reg, cd1_reg, t1_reg, h1_reg}),
        .out_valid (dv_valid),
        .out_quo   (step_quo),
        .out_side  (dv_side)
    );

    assign {raw_d, col_d, cd_d, t_d, h_d} = dv_side;

    // Stage 2: step saturation and clipping against the screen height.
    logic [31:0]      step_w;
    logic [ROW_W-1:0] step_sat;
    logic             over;
    logic [NUM_W-1:0] excess;
    logic [CFG_W-1:0] height;

    always_comb begin
        step_w   = 32'(step_quo);
        step_sat = (step_w > 32'hFFFF) ? 16'hFFFF : step_w[ROW_W-1:0];
        over     = (raw_d > NUM_W'(h_d));
        excess   = over ? (raw_d - NUM_W'(h_d)) : '0;
        height   = over ? h_d : raw_d[CFG_W-1:0];
    end

    logic              v2_reg;
    logic [ROW_W-1:0]  step2_reg;
    logic [NUM_W-1:0]  ex2_reg;
    logic [CFG_W-1:0]  ht2_reg;
    logic [TOP_W-1:0]  top2_reg;
    logic [COL_W-1:0]  col2_reg;
    logic [DIST_W-1:0] cd2_reg;
    logic [TEX_W-1:0]  t2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            step2_reg <= step_sat;
            ex2_reg   <= excess;
            ht2_reg   <= height;
            top2_reg  <= h_d[CFG_W-1:1] - height[CFG_W-1:1];
            col2_reg  <= col_d;
            cd2_reg   <= cd_d;
            t2_reg    <= t_d;
        end
    end

    // Stage 3: clipped rows times step.
    logic              v3_reg;
    logic [NUM_W+15:0] prod3_reg;
    logic [ROW_W-1:0]  step3_reg;
    logic [CFG_W-1:0]  ht3_reg;
    logic [TOP_W-1:0]  top3_reg;
    logic [COL_W-1:0]  col3_reg;
    logic [DIST_W-1:0] cd3_reg;
    logic [TEX_W-1:0]  t3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod3_reg <= (NUM_W+16)'(ex2_reg) * (NUM_W+16)'(step2_reg);
            step3_reg <= step2_reg;
            ht3_reg   <= ht2_reg;
            top3_reg  <= top2_reg;
            col3_reg  <= col2_reg;
            cd3_reg   <= cd2_reg;
            t3_reg    <= t2_reg;
        end
    end

    // Stage 4: halve and saturate the start row.
    logic [NUM_W+15:0] half;
    logic [ROW_W-1:0]  start_sat;
    always_comb begin
        half      = prod3_reg >> 1;
        start_sat = (|half[NUM_W+15:16]) ? 16'hFFFF : half[ROW_W-1:0];
    end

    logic              v4_reg;
    logic [ROW_W-1:0]  start4_reg, step4_reg;
    logic [CFG_W-1:0]  ht4_reg;
    logic [TOP_W-1:0]  top4_reg;
    logic [COL_W-1:0]  col4_reg;
    logic [DIST_W-1:0] cd4_reg;
    logic [TEX_W-1:0]  t4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            start4_reg <= start_sat;
            step4_reg  <= step3_reg;
            ht4_reg    <= ht3_reg;
            top4_reg   <= top3_reg;
            col4_reg   <= col3_reg;
            cd4_reg    <= cd3_reg;
            t4_reg     <= t3_reg;
        end
    end

    assign out_valid              = v4_reg;
    assign out_wall_height        = ht4_reg;
    assign out_wall_top           = top4_reg;
    assign out_column_x           = col4_reg;
    assign out_tex_column         = t4_reg;
    assign out_tex_row_start      = start4_reg;
    assign out_tex_row_step       = step4_reg;
    assign out_corrected_distance = cd4_reg;

endmodule
`default_nettype wire

FILE: rtl/wsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wall slice projection port checker
// Watches the top level's handshakes and flags broken result delivery.
// ----------------------------------------------------------------------------
module wsp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [11:0] m_wall_height,
    input wire logic [15:0] m_tex_row_step
);

    // A held result stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    // A held result keeps its wall height and texture step.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_wall_height) && $stable(m_tex_row_step))
        else $error("result item changed while stalled");

    // Input backpressure only appears while a result is being held.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

endmodule

bind wall_slice_projection_unit wsp_checker u_wsp_checker (.*);
`default_nettype wire

FILE: verif/wall_slice_projection_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall slice projection unit testbench
// Drives ray hits through the block, predicts each wall column from a local
// model of the projection math and compares every result item in order.
// Screen geometry is changed between phases through the register port.
// ----------------------------------------------------------------------------

// One predicted or observed wall column.
typedef struct packed {
    logic [11:0] wall_height;
    logic [10:0] wall_top;
    logic [10:0] column_x;
    logic [5:0]  tex_column;
    logic [15:0] tex_row_start;
    logic [15:0] tex_row_step;
    logic [23:0] corrected_distance;
} column_t;

// Ordered store of predicted wall columns, checked against the result items.
class column_scoreboard;
    column_t pending[$];
    int      errors;

    function void note_hit(column_t c);
        pending.push_back(c);
    endfunction

    function void check_column(column_t got);
        column_t exp;
        if (pending.size() == 0) begin
            $error("result item with no expected column");
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.wall_height !== exp.wall_height) begin
            $error("wall_height exp %0d got %0d", exp.wall_height, got.wall_height);
            errors++;
        end
        if (got.wall_top !== exp.wall_top) begin
            $error("wall_top exp %0d got %0d", exp.wall_top, got.wall_top);
            errors++;
        end
        if (got.column_x !== exp.column_x) begin
            $error("column_x exp %0d got %0d", exp.column_x, got.column_x);
            errors++;
        end
        if (got.tex_column !== exp.tex_column) begin
            $error("tex_column exp %0d got %0d", exp.tex_column, got.tex_column);
            errors++;
        end
        if (got.tex_row_start !== exp.tex_row_start) begin
            $error("tex_row_start exp %0d got %0d", exp.tex_row_start,
                   got.tex_row_start);
            errors++;
        end
        if (got.tex_row_step !== exp.tex_row_step) begin
            $error("tex_row_step exp %0d got %0d", exp.tex_row_step, got.tex_row_step);
            errors++;
        end
        if (got.corrected_distance !== exp.corrected_distance) begin
            $error("corrected_distance exp %0d got %0d", exp.corrected_distance,
                   got.corrected_distance);
            errors++;
        end
    endfunction
endclass

module wall_slice_projection_unit_tb;
    import wsp_pkg::*;

    localparam int unsigned TEX_SIZE   = 64;
    localparam int unsigned PROJ_SCALE = 128;
    localparam int unsigned ANG_BITS   = 16;
    localparam int unsigned SEG_SHIFT  = ANG_BITS - 7;
    localparam int unsigned QUARTER    = 1 << (ANG_BITS - 2);
    localparam int unsigned HALF       = 1 << (ANG_BITS - 1);
    // Drain with margin over the block's pipeline depth.
    localparam int          DRAIN_CYCLES = 80;
    localparam longint      CYCLE_LIMIT  = 400000;

    // Quarter-wave cosine, Q1.15, used only by the predictor.
    localparam int unsigned COS_TABLE [0:32] = '{
        32768, 32729, 32610, 32413, 32138, 31786, 31357, 30853,
        30274, 29622, 28899, 28106, 27246, 26320, 25330, 24279,
        23170, 22006, 20788, 19520, 18205, 16846, 15447, 14010,
        12540, 11039, 9512, 7962, 6393, 4808, 3212, 1608, 0};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_player_angle = '0, s_ray_angle = '0;
    logic signed [15:0] s_sway_angle = '0;
    logic [23:0] s_hit_distance = '0;
    logic [15:0] s_hit_x = '0, s_hit_y = '0;
    logic        s_hit_on_horizontal = 1'b0;
    logic [10:0] s_ray_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_wall_height;
    logic [10:0] m_wall_top, m_column_x;
    logic [5:0]  m_tex_column;
    logic [15:0] m_tex_row_start, m_tex_row_step;
    logic [23:0] m_corrected_distance;

    wall_slice_projection_unit dut (.*);

    always #6 aclk = ~aclk;

    column_scoreboard columns = new();

    // Local copy of the screen geometry registers.
    logic [11:0] screen_h = SCREEN_HEIGHT_RST;
    logic [11:0] screen_w = SCREEN_WIDTH_RST;
    logic [11:0] rays     = RAY_COUNT_RST;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    longint cycles = 0;

    // Cosine of a wrapped angle difference, clamped at zero for backward views.
    function automatic longint unsigned view_cosine(logic [15:0] ang);
        int unsigned q, r, idx, frac, a, b;
        q = ang[15:14];
        r = ang & (QUARTER - 1);
        if (q == 1 || q == 2) return 0;
        if (q == 3) r = QUARTER - r;
        idx = r >> SEG_SHIFT;
        frac = r & ((1 << SEG_SHIFT) - 1);
        if (idx >= 32) return COS_TABLE[32];
        a = COS_TABLE[idx];
        b = COS_TABLE[idx + 1];
        return a - (((a - b) * frac) >> SEG_SHIFT);
    endfunction

    function automatic column_t project_hit(
            logic [15:0] pa, logic [15:0] ra, logic signed [15:0] sw,
            logic [23:0] hit_dist, logic [15:0] hx, logic [15:0] hy,
            logic horiz, logic [10:0] ridx);
        column_t c;
        logic [15:0] diff;
        longint unsigned cd, div, raw, step, start, height, h, tx;
        h = screen_h;
        diff = pa - ra - sw;
        cd = (longint'(hit_dist) * view_cosine(diff)) >> 15;
        div = (cd == 0) ? 1 : cd;
        raw = (longint'(PROJ_SCALE) * h * 256) / div;
        if (raw == 0) raw = 1;
        step = (longint'(TEX_SIZE) << 10) / raw;
        if (step > 65535) step = 65535;
        start = 0;
        height = raw;
        if (raw > h) begin
            start = ((raw - h) * step) >> 1;
            if (start > 65535) start = 65535;
            height = h;
        end
        if (horiz) begin
            tx = (hx >> 1) % TEX_SIZE;
            if (ra < HALF) tx = TEX_SIZE - 1 - tx;
        end else begin
            tx = (hy >> 1) % TEX_SIZE;
            if (ra > QUARTER && ra < 3 * QUARTER) tx = TEX_SIZE - 1 - tx;
        end
        c.wall_height = height[11:0];
        c.wall_top = 11'((h >> 1) - (height >> 1));
        c.column_x = (rays == 0) ? 11'd0 : 11'(longint'(ridx) * (screen_w / rays));
        c.tex_column = tx[5:0];
        c.tex_row_start = start[15:0];
        c.tex_row_step = step[15:0];
        c.corrected_distance = cd[23:0];
        return c;
    endfunction

    // Note every accepted hit and check every accepted column at the clock edge.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && s_valid && s_ready)
            columns.note_hit(project_hit(s_player_angle, s_ray_angle, s_sway_angle,
                s_hit_distance, s_hit_x, s_hit_y, s_hit_on_horizontal, s_ray_index));
        if (aresetn && m_valid && m_ready)
            columns.check_column({m_wall_height, m_wall_top, m_column_x, m_tex_column,
                m_tex_row_start, m_tex_row_step, m_corrected_distance});
    end

    // Receiver: stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Runaway guard.
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("wall_slice_projection_unit_tb: FAIL");
            $finish;
        end
    end

    // Setup phase, access phase, then the port goes idle.
    task automatic write_reg(reg_idx_t idx, logic [11:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {20'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SCREEN_HEIGHT: screen_h = value;
            REG_SCREEN_WIDTH:  screen_w = value;
            default:           rays = value;
        endcase
        @(posedge aclk);
    endtask

    // Valid drops only while the sender idles; back-to-back items keep it high.
    task automatic send_hit(logic [15:0] pa, logic [15:0] ra, logic [15:0] sw,
                            logic [23:0] hit_dist, logic [15:0] hx, logic [15:0] hy,
                            logic horiz, logic [10:0] ridx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_player_angle <= pa;
        s_ray_angle <= ra;
        s_sway_angle <= sw;
        s_hit_distance <= hit_dist;
        s_hit_x <= hx;
        s_hit_y <= hy;
        s_hit_on_horizontal <= horiz;
        s_ray_index <= ridx;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random hit: mostly near-forward rays at plausible distances, with some
    // fully random angles and distances to reach the clamps.
    task automatic send_random_hit();
        logic [15:0] pa, ra, sw;
        logic [23:0] hit_dist;
        pa = 16'($urandom);
        ra = 16'($urandom);
        if ($urandom_range(3) != 0) begin
            sw = 16'($urandom_range(2047)) - 16'd1024;
            ra = pa - sw - 16'($urandom_range(2 * QUARTER) - QUARTER);
        end else begin
            sw = 16'($urandom);
        end
        case ($urandom_range(3))
            0: hit_dist = 24'($urandom_range(4095));
            1: hit_dist = 24'($urandom_range(1 << 18));
            default: hit_dist = 24'($urandom);
        endcase
        send_hit(pa, ra, sw, hit_dist, 16'($urandom), 16'($urandom),
                 1'($urandom_range(1)), 11'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (columns.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero and full distances, all quadrants, wrap and sway extremes,
        // both hit orientations at the mirror boundaries, field extremes.
        send_hit(16'd0, 16'd0, 16'sd0, 24'd0, 16'd0, 16'd0, 1'b0, 11'd0);
        send_hit(16'd0, 16'd0, 16'sd0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 11'h7FF);
        send_hit(16'd0, 16'd0, 16'sd0, 24'd1, 16'd2, 16'd2, 1'b1, 11'd1);
        send_hit(16'd0, 16'h4000, 16'sd0, 24'd5000, 16'd9, 16'd9, 1'b0, 11'd5);
        send_hit(16'd0, 16'h4001, 16'sd0, 24'd5000, 16'd9, 16'd9, 1'b0, 11'd5);
        send_hit(16'd0, 16'hC000, 16'sd0, 24'd5000, 16'd9, 16'd9, 1'b0, 11'd5);
        send_hit(16'd0, 16'hBFFF, 16'sd0, 24'd5000, 16'd9, 16'd9, 1'b0, 11'd5);
        send_hit(16'd0, 16'h8000, 16'sd0, 24'd5000, 16'd9, 16'd9, 1'b1, 11'd5);
        send_hit(16'd0, 16'h7FFF, 16'sd0, 24'd5000, 16'd9, 16'd9, 1'b1, 11'd5);
        send_hit(16'hFFFF, 16'd0, 16'sh7FFF, 24'd300, 16'd7, 16'd7, 1'b1, 11'd9);
        send_hit(16'd0, 16'hFFFF, -16'sh8000, 24'd300, 16'd7, 16'd7, 1'b0, 11'd9);
        send_hit(16'h2000, 16'd0, 16'sd0, 24'd70000, 16'd100, 16'd100, 1'b1, 11'd3);
        send_hit(16'hE000, 16'd0, -16'sd1, 24'd70000, 16'd100, 16'd100, 1'b0, 11'd3);
        send_hit(16'h0200, 16'd0, 16'sd0, 24'd32768, 16'd126, 16'd127, 1'b0, 11'd7);
        send_hit(16'h5555, 16'hAAAA, 16'sh5555, 24'hAAAAAA, 16'h5555, 16'hAAAA,
                 1'b1, 11'h555);
        send_hit(16'hAAAA, 16'h5555, 16'shAAAA, 24'h555555, 16'hAAAA, 16'h5555,
                 1'b0, 11'h2AA);
        drain();

        // Extreme geometry: zero height and zero ray count, then maximum height and width with a single ray.
        write_reg(REG_SCREEN_HEIGHT, 12'd0);
        write_reg(REG_RAY_COUNT, 12'd0);
        repeat (30) send_random_hit();
        drain();
        write_reg(REG_SCREEN_HEIGHT, 12'hFFF);
        write_reg(REG_SCREEN_WIDTH, 12'hFFF);
        write_reg(REG_RAY_COUNT, 12'd1);
        repeat (60) send_random_hit();
        drain();

        // Random phases with different idling and geometry.
        write_reg(REG_SCREEN_HEIGHT, 12'd2048);
        write_reg(REG_SCREEN_WIDTH, 12'd2048);
        write_reg(REG_RAY_COUNT, 12'd2048);
        send_idle_pct = 33;
        recv_idle_pct = 50;
        repeat (270) send_random_hit();
        drain();
        write_reg(REG_SCREEN_HEIGHT, 12'd1);
        write_reg(REG_SCREEN_WIDTH, 12'd640);
        write_reg(REG_RAY_COUNT, 12'd7);
        send_idle_pct = 50;
        recv_idle_pct = 33;
        repeat (270) send_random_hit();
        drain();
        write_reg(REG_SCREEN_HEIGHT, 12'd480);
        write_reg(REG_SCREEN_WIDTH, 12'd1);
        write_reg(REG_RAY_COUNT, 12'd320);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (270) send_random_hit();

        drain();
        if (columns.errors == 0 && columns.pending.size() == 0)
            $display("wall_slice_projection_unit_tb: PASS");
        else
            $display("wall_slice_projection_unit_tb: FAIL");
        $finish;
    end
endmodule
